### rtl/core/qwto_pkg.sv
// Shared types and constants for the quarter-wave table oscillator.
package qwto_pkg;

   localparam int DATA_W     = 32;
   localparam int FUNC_W     = 3;
   localparam int ADDR_W     = 10;
   localparam int SIZE_W     = 11;
   localparam int STRIDE_W   = 10;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE  = 3'd0,
      FUNC_START  = 3'd1,
      FUNC_STOP   = 3'd2,
      FUNC_SAMPLE = 3'd3,
      FUNC_MIX    = 3'd4,
      FUNC_QUERY  = 3'd5
   } func_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_TABLE_SIZE     = 3'd0,
      REG_STRIDE         = 3'd1,
      REG_ERROR_PER_HALF = 3'd2,
      REG_ERROR_LIMIT    = 3'd3,
      REG_IDLE_LEVEL     = 3'd4
   } reg_idx_type;

   // Wave quarter being played; the inserted end sample never rests in state.
   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_FWD  = 5'b00010,
      PH_BWD  = 5'b00100,
      PH_NFWD = 5'b01000,
      PH_NBWD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   table_size;
      logic [STRIDE_W-1:0] stride;
      logic [DATA_W-1:0]   error_per_half;
      logic [DATA_W-1:0]   error_limit;
      logic [DATA_W-1:0]   idle_level;
   } cfg_type;

   // Work handed from the sequencer to the output stage, one per accepted word.
   typedef struct packed {
      logic              valid;
      logic              use_mem;
      logic              negate;
      logic              mix_en;
      logic [DATA_W-1:0] imm;
      logic [DATA_W-1:0] mix;
      logic              done;
   } issue_type;

endpackage

### rtl/core/qwto_csr.sv
// Configuration register file on an APB-style port.
module qwto_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [qwto_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [qwto_pkg::DATA_W-1:0]            pwdata,
   output logic [qwto_pkg::DATA_W-1:0]            prdata,
   output logic                                   pready,
   output qwto_pkg::cfg_type                      cfg
);

   qwto_pkg::cfg_type                  cfg_ff;
   qwto_pkg::cfg_type                  cfg_in;
   logic                               wr_en;
   logic [qwto_pkg::REG_IDX_W-1:0]     idx;

   assign pready = 1'b1;
   assign idx    = paddr[qwto_pkg::CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            qwto_pkg::REG_TABLE_SIZE:     cfg_in.table_size = pwdata[qwto_pkg::SIZE_W-1:0];
            qwto_pkg::REG_STRIDE:         cfg_in.stride = pwdata[qwto_pkg::STRIDE_W-1:0];
            qwto_pkg::REG_ERROR_PER_HALF: cfg_in.error_per_half = pwdata;
            qwto_pkg::REG_ERROR_LIMIT:    cfg_in.error_limit = pwdata;
            qwto_pkg::REG_IDLE_LEVEL:     cfg_in.idle_level = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         qwto_pkg::REG_TABLE_SIZE:     prdata = qwto_pkg::DATA_W'(cfg_ff.table_size);
         qwto_pkg::REG_STRIDE:         prdata = qwto_pkg::DATA_W'(cfg_ff.stride);
         qwto_pkg::REG_ERROR_PER_HALF: prdata = cfg_ff.error_per_half;
         qwto_pkg::REG_ERROR_LIMIT:    prdata = cfg_ff.error_limit;
         qwto_pkg::REG_IDLE_LEVEL:     prdata = cfg_ff.idle_level;
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_size     <= qwto_pkg::SIZE_W'(1);
         cfg_ff.stride         <= qwto_pkg::STRIDE_W'(1);
         cfg_ff.error_per_half <= '0;
         cfg_ff.error_limit    <= '0;
         cfg_ff.idle_level     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/qwto_table.sv
// Quarter-wave sample memory: one write port, one read port with registered data.
module qwto_table #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
   input  logic [qwto_pkg::DATA_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   output logic [qwto_pkg::DATA_W-1:0]       rd_data
);

   logic [qwto_pkg::DATA_W-1:0] entry_ff [TABLE_DEPTH];
   logic [qwto_pkg::DATA_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // data holds until the next read, so a stalled word keeps its sample
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

endmodule

### rtl/core/qwto_seq.sv
// Wave sequencer: phase, position, error and stop state; issues table accesses.
module qwto_seq #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [qwto_pkg::FUNC_W-1:0]       func,
   input  logic [qwto_pkg::ADDR_W-1:0]       addr,
   input  logic [qwto_pkg::DATA_W-1:0]       data,
   input  logic [qwto_pkg::DATA_W-1:0]       mix_in,
   input  qwto_pkg::cfg_type                 cfg,
   output logic                              wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
   output logic [qwto_pkg::DATA_W-1:0]       wr_data,
   output logic                              rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   output qwto_pkg::issue_type               issue
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = (AW + 1 > qwto_pkg::SIZE_W) ? AW + 1 : qwto_pkg::SIZE_W;
   localparam int PW = ((AW > qwto_pkg::STRIDE_W) ? AW : qwto_pkg::STRIDE_W) + 2;
   localparam int WW = (AW + 1 > qwto_pkg::ADDR_W) ? AW + 1 : qwto_pkg::ADDR_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [WW-1:0] DEPTH_W = WW'(TABLE_DEPTH);

   qwto_pkg::phase_type          phase_ff;
   qwto_pkg::phase_type          phase_in;
   logic [PW-1:0]                pos_ff;
   logic [PW-1:0]                pos_in;
   logic                         stop_ff;
   logic                         stop_in;
   logic [qwto_pkg::DATA_W-1:0]  err_ff;
   logic [qwto_pkg::DATA_W-1:0]  err_in;

   logic [CW-1:0]                size_ext;
   logic [CW-1:0]                size_c;
   logic [CW-1:0]                last_c;
   logic [AW-1:0]                last;
   logic [PW-1:0]                last_p;
   logic [PW-1:0]                stride_p;
   logic                         in_range;
   logic                         fwd;
   logic [PW-1:0]                inc_src;
   logic [PW-1:0]                pos_up;
   logic [PW-1:0]                dec_src;
   logic [PW-1:0]                pos_dn;
   logic [qwto_pkg::DATA_W-1:0]  err_up;
   logic [qwto_pkg::DATA_W-1:0]  err_ex;
   logic                         extra;
   logic [WW-1:0]                wr_addr_ext;

   // table size 0 acts as 1, oversize acts as the full depth
   assign size_ext = CW'(cfg.table_size);
   assign size_c   = (size_ext == '0) ? CW'(1) : ((size_ext > DEPTH_C) ? DEPTH_C : size_ext);
   assign last_c   = size_c - CW'(1);
   assign last     = last_c[AW-1:0];
   assign last_p   = PW'(last);
   assign stride_p = PW'(cfg.stride);
   assign in_range = (pos_ff <= last_p);
   assign fwd      = (phase_ff == qwto_pkg::PH_FWD) || (phase_ff == qwto_pkg::PH_NFWD);

   // turning from backward restarts at entry 0; turning from forward steps back from last
   assign inc_src  = in_range ? pos_ff : '0;
   assign pos_up   = inc_src + stride_p;
   assign dec_src  = (fwd && !in_range) ? last_p : pos_ff;
   assign pos_dn   = (stride_p > dec_src) ? '1 : (dec_src - stride_p);

   assign err_up   = err_ff + cfg.error_per_half;
   assign err_ex   = err_ff + cfg.error_per_half - cfg.error_limit;
   assign extra    = (err_up > cfg.error_limit);

   assign wr_addr_ext = WW'(addr);
   assign wr_addr     = wr_addr_ext[AW-1:0];
   assign wr_data     = data;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      stop_in       = stop_ff;
      err_in        = err_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = pos_ff[AW-1:0];
      issue.valid   = accept;
      issue.use_mem = 1'b0;
      issue.negate  = 1'b0;
      issue.mix_en  = 1'b0;
      issue.imm     = '0;
      issue.mix     = mix_in;
      issue.done    = 1'b0;
      if (accept) begin
         unique case (func) inside
            qwto_pkg::FUNC_WRITE: begin
               wr_en = (wr_addr_ext < DEPTH_W);
            end
            qwto_pkg::FUNC_START: begin
               phase_in = qwto_pkg::PH_FWD;
               pos_in   = '0;
               stop_in  = 1'b0;
               err_in   = '0;
            end
            qwto_pkg::FUNC_STOP: begin
               stop_in = 1'b1;
            end
            qwto_pkg::FUNC_SAMPLE, qwto_pkg::FUNC_MIX: begin
               issue.mix_en = (func == qwto_pkg::FUNC_MIX);
               unique case (phase_ff) inside
                  qwto_pkg::PH_FWD, qwto_pkg::PH_NFWD: begin
                     rd_en         = 1'b1;
                     issue.use_mem = 1'b1;
                     issue.negate  = (phase_ff == qwto_pkg::PH_NFWD);
                     if (in_range) begin
                        pos_in = pos_up;
                     end else begin
                        // half-wave end: both the inserted sample and the turn read last
                        rd_addr  = last;
                        phase_in = (phase_ff == qwto_pkg::PH_FWD) ? qwto_pkg::PH_BWD
                                                                  : qwto_pkg::PH_NBWD;
                        if (extra) begin
                           err_in = err_ex;
                           pos_in = last_p;
                        end else begin
                           err_in = err_up;
                           pos_in = pos_dn;
                        end
                     end
                  end
                  qwto_pkg::PH_BWD, qwto_pkg::PH_NBWD: begin
                     if (in_range) begin
                        rd_en         = 1'b1;
                        issue.use_mem = 1'b1;
                        issue.negate  = (phase_ff == qwto_pkg::PH_NBWD);
                        pos_in        = pos_dn;
                     end else if (phase_ff == qwto_pkg::PH_BWD && stop_ff) begin
                        phase_in  = qwto_pkg::PH_IDLE;
                        pos_in    = '0;
                        issue.imm = cfg.idle_level;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        issue.use_mem = 1'b1;
                        issue.negate  = (phase_ff == qwto_pkg::PH_BWD);
                        phase_in      = (phase_ff == qwto_pkg::PH_BWD) ? qwto_pkg::PH_NFWD
                                                                       : qwto_pkg::PH_FWD;
                        pos_in        = pos_up;
                     end
                  end
                  default: begin
                     issue.imm = cfg.idle_level;
                  end
               endcase
            end
            qwto_pkg::FUNC_QUERY: begin
               if (stop_ff && phase_ff == qwto_pkg::PH_IDLE) begin
                  stop_in    = 1'b0;
                  issue.done = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qwto_pkg::PH_IDLE;
         pos_ff   <= '0;
         stop_ff  <= 1'b0;
         err_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
         err_ff   <= err_in;
      end
   end

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && func == qwto_pkg::FUNC_START |=>
         phase_ff == qwto_pkg::PH_FWD && pos_ff == '0 && err_ff == '0 && !stop_ff)
      else $error("start did not reset wave state");

   a_read_source: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> accept && (func == qwto_pkg::FUNC_SAMPLE || func == qwto_pkg::FUNC_MIX))
      else $error("table read without a sample word");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == qwto_pkg::PH_IDLE |-> pos_ff == '0)
      else $error("idle with nonzero position");

endmodule

### rtl/core/qwto_out.sv
// Output stage: sign and mix the table word, then the result register.
module qwto_out (
   input  logic                          clock,
   input  logic                          reset,
   input  qwto_pkg::issue_type           issue,
   input  logic [qwto_pkg::DATA_W-1:0]   rd_data,
   output logic                          s1_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [qwto_pkg::DATA_W-1:0]   rsp_sample,
   output logic                          rsp_stop_done
);

   qwto_pkg::issue_type          s1_ff;
   qwto_pkg::issue_type          s1_in;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [qwto_pkg::DATA_W-1:0]  sample_ff;
   logic [qwto_pkg::DATA_W-1:0]  sample_in;
   logic                         done_ff;
   logic                         done_in;
   logic                         s1_adv;
   logic [qwto_pkg::DATA_W-1:0]  val;
   logic [qwto_pkg::DATA_W-1:0]  term;
   logic [qwto_pkg::DATA_W-1:0]  base;
   logic [qwto_pkg::DATA_W-1:0]  sum;

   assign s1_adv   = !out_valid_ff || !rsp_stall;
   assign s1_ready = !s1_ff.valid || s1_adv;

   // mix - v folded into one adder: mix + ~v + 1
   assign val  = s1_ff.use_mem ? rd_data : s1_ff.imm;
   assign term = s1_ff.negate ? ~val : val;
   assign base = s1_ff.mix_en ? s1_ff.mix : '0;
   assign sum  = base + term + qwto_pkg::DATA_W'(s1_ff.negate);

   always_comb begin
      s1_in        = s1_ready ? issue : s1_ff;
      out_valid_in = out_valid_ff;
      sample_in    = sample_ff;
      done_in      = done_ff;
      if (s1_adv) begin
         out_valid_in = s1_ff.valid;
         sample_in    = sum;
         done_in      = s1_ff.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      done_ff   <= done_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_sample    = sample_ff;
   assign rsp_stop_done = done_ff;

   a_rd_held: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.use_mem && !s1_adv |=> $stable(rd_data))
      else $error("table data changed under a held word");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_done |-> rsp_sample == '0)
      else $error("stop result carries a sample");

endmodule

### rtl/core/quarter_wave_table_oscillator_unit.sv
// An accepted word passes through the stage-1 register, then the result register, which holds under rsp_stall.
// Throughput: one word per cycle while rsp_stall does not hold the result; the table has one read port whose data is
// registered, and the next position and phase are settled in the accept cycle.
// Reset clears phase (idle), position, stop and error state and the pipeline valid registers.
// The table is not cleared: entries read as undefined until written.
module quarter_wave_table_oscillator_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [qwto_pkg::FUNC_W-1:0]         req_func,
   input  logic [qwto_pkg::ADDR_W-1:0]         req_addr,
   input  logic [qwto_pkg::DATA_W-1:0]         req_data,
   input  logic [qwto_pkg::DATA_W-1:0]         req_mix_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qwto_pkg::DATA_W-1:0]         rsp_sample,
   output logic                                rsp_stop_done,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [qwto_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [qwto_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [qwto_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   qwto_pkg::cfg_type            cfg;
   qwto_pkg::issue_type          issue;
   logic                         accept;
   logic                         s1_ready;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [qwto_pkg::DATA_W-1:0]  wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [qwto_pkg::DATA_W-1:0]  rd_data;

   assign req_stall = !s1_ready;
   assign accept    = req_valid && !req_stall;

   qwto_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   qwto_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req_func),
      .addr    (req_addr),
      .data    (req_data),
      .mix_in  (req_mix_in),
      .cfg     (cfg),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .issue   (issue)
   );

   qwto_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   qwto_out u_out (
      .clock         (clock),
      .reset         (reset),
      .issue         (issue),
      .rd_data       (rd_data),
      .s1_ready      (s1_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_stop_done (rsp_stop_done)
   );

endmodule
